@@ rtl/core/idalc_pkg.sv @@
// ----------------------------------------------------------------------------
// idalc_pkg: shared types and codes of the ID allocator
// Field widths, opcode and status codes, and the command structs that pass
// between the allocator control and its two memories.
// ----------------------------------------------------------------------------
package idalc_pkg;

	localparam int OPCODE_W = 2;
	localparam int TARGET_W = 8;
	localparam int STATUS_W = 2;
	localparam int RESULT_W = 8;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam opcode_t OP_ALLOC = 2'd0;
	localparam opcode_t OP_FREE  = 2'd1;
	localparam opcode_t OP_QUERY = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_DEAD  = 2'd2;
	localparam status_t ST_NEVER = 2'd3;

	// Free stack commands: read top entry, push, pop.
	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} stack_cmd_t;

	// Alive map commands: read one flag, write one flag.
	typedef struct packed {
		logic rd;
		logic wr;
		logic wr_val;
	} alive_cmd_t;

endpackage

@@ rtl/core/idalc_ifs.sv @@
// ----------------------------------------------------------------------------
// idalc request and response channels
// Valid/ready channels; a transaction completes when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface idalc_req_if;
	import idalc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TARGET_W-1:0] target_id;

	modport source (output valid, output opcode, output target_id, input ready);
	modport sink   (input valid, input opcode, input target_id, output ready);
endinterface

interface idalc_rsp_if;
	import idalc_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [RESULT_W-1:0] result_id;

	modport source (output valid, output status, output result_id, input ready);
	modport sink   (input valid, input status, input result_id, output ready);
endinterface

@@ rtl/core/idalc_free_stack.sv @@
// ----------------------------------------------------------------------------
// idalc_free_stack: LIFO of freed IDs
// Synchronous memory with a registered read of the top entry and the stack
// depth counter.
// ----------------------------------------------------------------------------
module idalc_free_stack #(
	parameter int MaxIds = 256,
	parameter int IdW    = 8,
	parameter int CntW   = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  idalc_pkg::stack_cmd_t  cmd,
	input  logic [IdW-1:0]         push_id,
	output logic [IdW-1:0]         top_id,
	output logic [CntW-1:0]        count
);
	import idalc_pkg::*;

	logic [IdW-1:0]  mem [MaxIds];
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] top_idx;
	logic            push_ok;

	assign top_idx = count_q - CntW'(1);
	// Drop a push that would overflow; cannot happen with consistent state.
	assign push_ok = cmd.push && (count_q < CntW'(MaxIds));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			top_id <= mem[top_idx[IdW-1:0]];
		end
		if (push_ok) begin
			mem[count_q[IdW-1:0]] <= push_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push_ok) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CntW'(1);
		end
	end

	assign count = count_q;

endmodule

@@ rtl/core/idalc_alive_map.sv @@
// ----------------------------------------------------------------------------
// idalc_alive_map: live flag per ID
// One-bit-wide synchronous memory, one read and one write port. No clearing:
// only the flags of IDs below the high-water mark are used, and each was written on issue.
// ----------------------------------------------------------------------------
module idalc_alive_map #(
	parameter int MaxIds = 256,
	parameter int IdW    = 8
) (
	input  logic                  clk,
	input  idalc_pkg::alive_cmd_t cmd,
	input  logic [IdW-1:0]        rd_addr,
	input  logic [IdW-1:0]        wr_addr,
	output logic                  rd_data
);
	import idalc_pkg::*;

	logic mem [MaxIds];

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data <= mem[rd_addr];
		end
		if (cmd.wr) begin
			mem[wr_addr] <= cmd.wr_val;
		end
	end

endmodule

@@ rtl/core/id_allocator_with_free_stack.sv @@
// ----------------------------------------------------------------------------
// id_allocator_with_free_stack: numeric ID allocator with a free-ID stack
// Top level: request sequencer, high-water counter and response register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per request: opcode (allocate, free, query)
//   and target_id. rsp returns exactly one transaction per request, in order:
//   status (ok/live, full, already dead, never issued) and result_id (the
//   granted ID for allocate, zero if full, otherwise target_id echoed back).
//   Allocate pops the most recently freed ID; with the stack empty it issues
//   the next fresh ID from the high-water counter, and reports full once all
//   MAX_IDS IDs are out. Free pushes a live ID and marks it dead.
// Sequence:
//   The accept edge reads the free stack top and the alive flag from their
//   synchronous memories; the commit edge, which can stall on the response
//   register, evaluates, writes both memories back and loads the response
//   register. A new request is not accepted until the previous one has been
//   evaluated; rsp.valid rises when the response register is loaded.
// Reset: counters and valid flags clear at once; no memory clearing pass, so
//   requests are accepted from the first cycle after reset.
// Stall: a waiting response holds in its register; the next request is still
//   accepted and waits in evaluation until the response register frees.
// ----------------------------------------------------------------------------
module id_allocator_with_free_stack #(
	parameter int MAX_IDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	idalc_req_if.sink   req,
	idalc_rsp_if.source rsp
);
	import idalc_pkg::*;

	localparam int IdW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int CntW = $clog2(MAX_IDS + 1);
	localparam int CmpW = (CntW > TARGET_W) ? CntW : TARGET_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                state_q;
	opcode_t             op_q;
	logic [TARGET_W-1:0] tid_q;
	logic [CntW-1:0]     high_water_q;
	logic                rsp_valid_q;
	status_t             status_q;
	logic [RESULT_W-1:0] result_q;

	logic            req_acc;
	logic            out_free;
	logic            commit;
	stack_cmd_t      stk_cmd;
	alive_cmd_t      alv_cmd;
	logic [IdW-1:0]  stk_top;
	logic [CntW-1:0] free_count;
	logic            alive_rd;
	logic [CmpW-1:0] req_tid_ext;
	logic [CmpW-1:0] tid_ext;
	logic [IdW-1:0]  tid_addr;
	logic            is_alloc;
	logic            is_free;
	logic            has_free;
	logic            has_fresh;
	logic            never;
	logic [IdW-1:0]  grant_id;
	logic [IdW-1:0]  alv_wr_addr;
	logic            hw_inc;
	status_t         status_d;
	logic [RESULT_W-1:0] result_d;

	// Take a new request only when the previous one has been evaluated.
	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// Evaluate once the response register can take the result.
	assign out_free = !rsp_valid_q || rsp.ready;
	assign commit   = (state_q == S_EXEC) && out_free;

	assign req_tid_ext = CmpW'(req.target_id);
	assign tid_ext     = CmpW'(tid_q);
	assign tid_addr    = tid_ext[IdW-1:0];

	assign is_alloc  = (op_q == OP_ALLOC);
	assign is_free   = (op_q == OP_FREE);
	assign has_free  = (free_count != '0);
	assign has_fresh = (high_water_q < CntW'(MAX_IDS));
	// Never issued: at or above the high-water mark or outside the ID range.
	assign never     = (tid_ext >= CmpW'(high_water_q)) || (tid_ext >= CmpW'(MAX_IDS));
	assign grant_id  = has_free ? stk_top : high_water_q[IdW-1:0];

	// Memory commands: read at accept, write back at commit.
	always_comb begin
		stk_cmd.rd   = req_acc;
		stk_cmd.pop  = commit && is_alloc && has_free;
		stk_cmd.push = commit && is_free && !never && alive_rd;

		alv_cmd.rd     = req_acc;
		alv_cmd.wr     = commit && ((is_alloc && (has_free || has_fresh)) ||
			(is_free && !never && alive_rd));
		alv_cmd.wr_val = is_alloc;
		alv_wr_addr    = is_alloc ? grant_id : tid_addr;

		hw_inc = commit && is_alloc && !has_free && has_fresh;
	end

	// Response of the request under evaluation.
	always_comb begin
		status_d = ST_OK;
		result_d = tid_q;
		if (is_alloc) begin
			if (has_free || has_fresh) begin
				result_d = RESULT_W'(grant_id);
			end else begin
				status_d = ST_FULL;
				result_d = '0;
			end
		end else if (never) begin
			status_d = ST_NEVER;
		end else if (!alive_rd) begin
			status_d = ST_DEAD;
		end
	end

	idalc_free_stack #(
		.MaxIds (MAX_IDS),
		.IdW    (IdW),
		.CntW   (CntW)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stk_cmd),
		.push_id (tid_addr),
		.top_id  (stk_top),
		.count   (free_count)
	);

	idalc_alive_map #(
		.MaxIds (MAX_IDS),
		.IdW    (IdW)
	) u_alive (
		.clk     (clk),
		.cmd     (alv_cmd),
		.rd_addr (req_tid_ext[IdW-1:0]),
		.wr_addr (alv_wr_addr),
		.rd_data (alive_rd)
	);

	// Sequencer and high-water counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			high_water_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (hw_inc) begin
				high_water_q <= high_water_q + CntW'(1);
			end
		end
	end

	// Capture the request payload.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q  <= req.opcode;
			tid_q <= req.target_id;
		end
	end

	// Response register: load at commit, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			result_q <= result_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.result_id = result_q;

	// Freed IDs on the stack never outnumber the IDs ever issued.
	a_stack_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		free_count <= high_water_q)
		else $error("free stack deeper than high-water mark");

	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		high_water_q <= CntW'(MAX_IDS))
		else $error("high-water mark beyond ID range");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.pop |-> free_count != '0)
		else $error("pop from empty free stack");

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q && state_q == S_IDLE)
		else $error("evaluated request did not load a response");

endmodule
